[rtl/kmpspm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KMP stream matcher package
// Shared codes, item kinds, queue entry and result types of the matcher.
// ----------------------------------------------------------------------------
package kmpspm_pkg;

    // Action codes as they arrive on the input stream.
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Width of the reported text positions.
    localparam int RES_POS_W = 32;

    // Item kind after classification in the front part.
    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_APPEND,
        KIND_TEXT,
        KIND_NOP
    } kind_t;

    // One entry of the queue between front and back.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } queue_item_t;

    // One result item; found sits in the lowest bit.
    typedef struct packed {
        logic [1:0]           status;
        logic [RES_POS_W-1:0] match_end;
        logic [RES_POS_W-1:0] match_start;
        logic                 found;
    } result_t;

    // Back part sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage : kmpspm_pkg
`default_nettype wire

[rtl/kmpspm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KMP stream matcher front part
// Accepts input items, classifies the action and holds them in a two-entry
// queue for the back part.
// ----------------------------------------------------------------------------
module kmpspm_front
    import kmpspm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_action,
    input  wire logic [7:0]  in_byte,
    output logic             q_valid,
    output queue_item_t      q_item,
    input  wire logic        q_pop
);

    queue_item_t entry_reg [2];
    queue_item_t entry_next [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    queue_item_t new_item;
    logic        push;
    logic        wr_idx;
    logic [1:0]  wr_pos;

    // Classify the incoming action.
    always_comb
    begin
        new_item.data = in_byte;
        unique case (in_action)
            ACT_CLEAR:  new_item.kind = KIND_CLEAR;
            ACT_APPEND: new_item.kind = KIND_APPEND;
            ACT_TEXT:   new_item.kind = KIND_TEXT;
            default:    new_item.kind = KIND_NOP;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[0];
    assign wr_pos   = count_reg - {1'b0, q_pop};
    assign wr_idx   = wr_pos[0];

    // Queue update: shift on pop, write behind the last valid entry.
    always_comb
    begin
        entry_next = entry_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, q_pop};
        if (q_pop)
        begin
            entry_next[0] = entry_reg[1];
        end
        if (push)
        begin
            entry_next[wr_idx] = new_item;
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Queue entries.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // The queue never holds more than two items.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    // The back part only pops a non-empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    // A push without a pop grows the queue by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");

endmodule : kmpspm_front
`default_nettype wire

[rtl/kmpspm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// KMP stream matcher back part
// Executes queued items: clears, appends pattern bytes while extending the
// failure table, and scans text bytes by following failure links one step
// per cycle. Results go to a one-entry output register.
// ----------------------------------------------------------------------------
module kmpspm_back
    import kmpspm_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int POS_BITS    = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire queue_item_t q_item,
    output logic             q_pop,
    output logic             res_valid,
    input  wire logic        res_ready,
    output result_t          res_item
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

    // Pattern and failure-link memories.
    logic [7:0]    pat_mem  [MAX_PATTERN];
    logic [AW-1:0] link_mem [MAX_PATTERN];
    logic [7:0]    pat_rd_reg;
    logic [AW-1:0] link_rd_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    pat_wdata;
    logic [AW-1:0] link_wdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] link_addr;

    // Control state.
    state_t        state_reg, state_next;
    logic [LW-1:0] plen_reg, plen_next;
    logic [LW-1:0] pb_reg, pb_next;
    logic [LW-1:0] matched_reg, matched_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [AW-1:0] link_last_reg, link_last_next;
    logic          out_valid_reg, out_valid_next;

    // Item being scanned.
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    byte_reg, byte_next;
    kind_t         kind_reg, kind_next;
    result_t       out_reg, out_next;

    // Helpers.
    logic          out_free;
    logic          is_append;
    logic          is_text;
    logic          needs_scan;
    logic          pat_hit;
    logic          step;
    logic [LW-1:0] final_len;
    logic          full_match;
    logic          load_out;
    result_t       res_new;
    logic [LW-1:0] plen_m1;
    logic [POS_BITS+LW-1:0] start_wide;
    logic [POS_BITS+RES_POS_W-1:0] start_ext;
    logic [POS_BITS+RES_POS_W-1:0] end_ext;

    assign out_free   = !out_valid_reg || res_ready;
    assign is_append  = (q_item.kind == KIND_APPEND);
    assign is_text    = (q_item.kind == KIND_TEXT);
    assign needs_scan = (is_append && plen_reg != '0 && plen_reg != MAX_LEN)
                     || (is_text && plen_reg != '0);
    assign pat_hit    = (pat_rd_reg == byte_reg);
    assign step       = (len_reg != '0) && !pat_hit;
    assign final_len  = len_reg + LW'(pat_hit);
    assign full_match = (final_len == plen_reg);

    // Match position arithmetic, modulo the position counter width.
    assign plen_m1    = plen_reg - LW'(1);
    assign start_wide = {{LW{1'b0}}, pos_reg} - {{POS_BITS{1'b0}}, plen_m1};
    assign start_ext  = {{RES_POS_W{1'b0}}, start_wide[POS_BITS-1:0]};
    assign end_ext    = {{RES_POS_W{1'b0}}, pos_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && needs_scan)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!step && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        q_pop          = 1'b0;
        load_out       = 1'b0;
        res_new        = '0;
        mem_we         = 1'b0;
        mem_waddr      = plen_reg[AW-1:0];
        pat_wdata      = byte_reg;
        link_wdata     = final_len[AW-1:0];
        plen_next      = plen_reg;
        pb_next        = pb_reg;
        matched_next   = matched_reg;
        pos_next       = pos_reg;
        link_last_next = link_last_reg;
        len_next       = len_reg;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && needs_scan)
                begin
                    q_pop     = 1'b1;
                    len_next  = is_append ? pb_reg : matched_reg;
                    byte_next = q_item.data;
                    kind_next = q_item.kind;
                end
                else if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    load_out = 1'b1;
                    case (q_item.kind)
                        KIND_CLEAR:
                        begin
                            plen_next    = '0;
                            pb_next      = '0;
                            matched_next = '0;
                            pos_next     = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (plen_reg == MAX_LEN)
                            begin
                                res_new.status = STATUS_FULL;
                            end
                            else
                            begin
                                // First pattern byte: its link is zero.
                                mem_we         = 1'b1;
                                mem_waddr      = '0;
                                pat_wdata      = q_item.data;
                                link_wdata     = '0;
                                link_last_next = '0;
                                pb_next        = '0;
                                plen_next      = LW'(1);
                            end
                        end
                        KIND_TEXT:
                        begin
                            res_new.status = STATUS_EMPTY;
                            pos_next       = pos_reg + POS_BITS'(1);
                        end
                        default:
                        begin
                            res_new = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    // Follow one failure link.
                    len_next = LW'(link_rd_reg);
                end
                else if (out_free)
                begin
                    load_out = 1'b1;
                    if (kind_reg == KIND_APPEND)
                    begin
                        mem_we         = 1'b1;
                        link_last_next = final_len[AW-1:0];
                        pb_next        = final_len;
                        plen_next      = plen_reg + LW'(1);
                    end
                    else
                    begin
                        if (full_match)
                        begin
                            res_new.found       = 1'b1;
                            res_new.match_start = start_ext[RES_POS_W-1:0];
                            res_new.match_end   = end_ext[RES_POS_W-1:0];
                            matched_next        = LW'(link_last_reg);
                        end
                        else
                        begin
                            matched_next = final_len;
                        end
                        pos_next = pos_reg + POS_BITS'(1);
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_next       = load_out ? res_new : out_reg;
        out_valid_next = load_out || (out_valid_reg && !res_ready);
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;

    // Read addresses follow the length the next cycle will compare.
    assign rd_addr   = len_next[AW-1:0];
    assign link_addr = (len_next == '0) ? '0 : AW'(len_next - LW'(1));

    // Pattern and link memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[mem_waddr]  <= pat_wdata;
            link_mem[mem_waddr] <= link_wdata;
        end
        pat_rd_reg  <= pat_mem[rd_addr];
        link_rd_reg <= link_mem[link_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plen_reg      <= '0;
            pb_reg        <= '0;
            matched_reg   <= '0;
            pos_reg       <= '0;
            link_last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plen_reg      <= plen_next;
            pb_reg        <= pb_next;
            matched_reg   <= matched_next;
            pos_reg       <= pos_next;
            link_last_reg <= link_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        len_reg  <= len_next;
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        out_reg  <= out_next;
    end

    // The pattern length never exceeds the store.
    a_plen_range: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= MAX_LEN)
        else $error("pattern length beyond store");

    // The matched length stays below the pattern length, or both are zero.
    a_matched_range: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg < plen_reg || (plen_reg == '0 && matched_reg == '0))
        else $error("matched length out of range");

    // While scanning, only written pattern entries are compared.
    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> len_reg < plen_reg)
        else $error("scan length reaches unwritten entry");

    // No item leaves the queue while one is being scanned.
    a_scan_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !q_pop)
        else $error("queue popped during scan");

endmodule : kmpspm_back
`default_nettype wire

[rtl/kmp_stream_pattern_matcher_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A clear, an unused action, the first pattern byte, a rejected byte or a text byte on an
// empty pattern goes from its queue entry straight to the output register; other appends
// and text bytes pass the scan registers and follow k failure links, one read each. Items
// needing no scan flow at one item per cycle while the output is not stalled; no item is
// taken during a scan. Reset clears the pattern length, match state, text position, item
// queue and output valid flag; the pattern and link memories are not cleared.
// ----------------------------------------------------------------------------
// KMP stream pattern matcher
// Streaming Knuth-Morris-Pratt matcher: a front queue classifies items and a
// back sequencer builds the failure table and scans text one link per cycle.
// ----------------------------------------------------------------------------
module kmp_stream_pattern_matcher_unit
    import kmpspm_pkg::*;
#(
    parameter int MAX_PATTERN = 64,
    parameter int POS_BITS    = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] item_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [0] found, [32:1] match_start,
                                        // [64:33] match_end, [66:65] status
);

    logic        q_valid;
    queue_item_t q_item;
    logic        q_pop;
    result_t     res_item;

    // Front: accept and classify.
    kmpspm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_byte   (s_tdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Back: table build and text scan.
    kmpspm_back #(
        .MAX_PATTERN (MAX_PATTERN),
        .POS_BITS    (POS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_item  (res_item)
    );

    // Pack the result item, padded to whole bytes.
    assign m_tdata = {5'b0, res_item};

endmodule : kmp_stream_pattern_matcher_unit
`default_nettype wire
